// File: rtl/gca_pkg.sv
// shared types, codes and helper functions of the graded cell grid
`default_nettype none
package gca_pkg;

  // default grid size
  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_GEN   = 2'd2;
  localparam logic [1:0] CMD_RAND  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_WRAP    = 3'd1;
  localparam logic [2:0] REG_BLOW    = 3'd2;
  localparam logic [2:0] REG_BHIGH   = 3'd3;
  localparam logic [2:0] REG_SLOW    = 3'd4;
  localparam logic [2:0] REG_SHIGH   = 3'd5;
  localparam logic [2:0] REG_SEED    = 3'd6;

  // neighbourhood modes
  localparam logic [2:0] MODE_MOORE1 = 3'd0;
  localparam logic [2:0] MODE_MOORE2 = 3'd1;
  localparam logic [2:0] MODE_VN1    = 3'd2;
  localparam logic [2:0] MODE_VN2    = 3'd3;
  localparam logic [2:0] MODE_WEIGHT = 3'd4;

  localparam logic [15:0] LFSR_MASK  = 16'hB400;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [7:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       op_done;
  } out_item_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [2:0]  mode;
    logic        wrap;
    logic [12:0] birth_low;
    logic [12:0] birth_high;
    logic [12:0] survive_low;
    logic [12:0] survive_high;
    logic        seed_wr;
    logic [15:0] seed;
  } cfg_t;

  // result handed to the output register
  typedef struct packed {
    logic       push;
    logic [7:0] value;
  } res_t;

  // one galois lfsr step
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

  // value mod 255 by folding the two bytes
  function automatic logic [7:0] gray_of(input logic [15:0] s);
    logic [8:0] t;
    t = {1'b0, s[15:8]} + {1'b0, s[7:0]};
    if (t >= 9'd510) begin
      t = t - 9'd510;
    end else if (t >= 9'd255) begin
      t = t - 9'd255;
    end
    return t[7:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/graded_cell_automaton.sv
// a read passes the read wait state before its result is pushed to the output
// register; a generation does 25 neighbourhood reads through the single bank
// read port per cell plus accumulate and write
// one command in flight; the next is taken while a result waits at the output
// after reset a clearing pass zeroes the grid, no item is taken meanwhile;
// configuration resets to its documented values
`default_nettype none
module graded_cell_automaton #(
  parameter int GRID_ROWS = gca_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = gca_pkg::GRID_COLS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gca_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gca_pkg::out_item_t      out_item_o
);

  logic [2:0]  mode_q;
  logic        wrap_q;
  logic [12:0] blow_q, bhigh_q, slow_q, shigh_q;
  logic        out_valid_q;
  logic [7:0]  out_val_q;
  gca_pkg::cfg_t cfg;
  gca_pkg::res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= gca_pkg::MODE_MOORE1;
      wrap_q  <= 1'b1;
      blow_q  <= 13'd510;
      bhigh_q <= 13'd765;
      slow_q  <= 13'd255;
      shigh_q <= 13'd765;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gca_pkg::REG_MODE:  mode_q  <= cfg_data_i[2:0];
        gca_pkg::REG_WRAP:  wrap_q  <= cfg_data_i[0];
        gca_pkg::REG_BLOW:  blow_q  <= cfg_data_i[12:0];
        gca_pkg::REG_BHIGH: bhigh_q <= cfg_data_i[12:0];
        gca_pkg::REG_SLOW:  slow_q  <= cfg_data_i[12:0];
        gca_pkg::REG_SHIGH: shigh_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{mode: mode_q, wrap: wrap_q, birth_low: blow_q, birth_high: bhigh_q,
                 survive_low: slow_q, survive_high: shigh_q,
                 seed_wr: cfg_we_i && (cfg_idx_i == gca_pkg::REG_SEED),
                 seed: cfg_data_i};

  gca_engine #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_ready_o, .in_item_i,
    .out_free_i(!out_valid_q || out_ready_i), .res_o(res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.push) begin
      out_val_q <= res.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = '{read_value: out_val_q, op_done: 1'b1};

endmodule
`default_nettype wire

// File: rtl/gca_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module gca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/gca_engine.sv
// command sequencer with two grid banks, neighbour walk and lfsr
`default_nettype none
module gca_engine #(
  parameter int GRID_ROWS = gca_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = gca_pkg::GRID_COLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gca_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire gca_pkg::in_item_t in_item_i,
  input  wire logic              out_free_i,
  output gca_pkg::res_t          res_o
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_GRD    = 3'd3;
  localparam logic [2:0] S_GACC   = 3'd4;
  localparam logic [2:0] S_GWR    = 3'd5;
  localparam logic [2:0] S_RAND   = 3'd6;
  localparam logic [2:0] S_PUSH   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              bank_q, bank_d;
  logic [RW-1:0]     r_q, r_d;
  logic [CW-1:0]     c_q, c_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic signed [2:0] dr_q, dr_d, dc_q, dc_d;
  logic              pend_q, pend_d, pzero_q, pzero_d;
  logic signed [2:0] pdr_q, pdr_d, pdc_q, pdc_d;
  logic [10:0]       inner_q, inner_d;
  logic [11:0]       outer_q, outer_d;
  logic [9:0]        p1_q, p1_d;
  logic [11:0]       p2_q, p2_d;
  logic [7:0]        v_q, v_d;
  logic [7:0]        res_q, res_d;
  logic              roff_q, roff_d;
  logic [15:0]       lfsr_q, lfsr_d;

  logic              rd_en, wr_en, wr_bank;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [7:0]        wr_data, rd0, rd1, rdata;

  // two banks: current grid and next generation
  gca_ram #(.WIDTH(8), .DEPTH(CELLS)) u_bank0 (
    .clk_i, .wr_en_i(wr_en && !wr_bank), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .rd_en_i(rd_en && !bank_q), .rd_addr_i(rd_addr), .rd_data_o(rd0)
  );
  gca_ram #(.WIDTH(8), .DEPTH(CELLS)) u_bank1 (
    .clk_i, .wr_en_i(wr_en && wr_bank), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .rd_en_i(rd_en && bank_q), .rd_addr_i(rd_addr), .rd_data_o(rd1)
  );

  assign rdata = bank_q ? rd1 : rd0;

  // sequencer
  always_comb begin
    int          nr, nc;
    logic        on_grid, in_grid, live_ok, birth_ok;
    logic [2:0]  ar, ac;
    logic [7:0]  g, newv;
    logic [12:0] sum;
    logic [15:0] ln;

    state_d = state_q; bank_d = bank_q; r_d = r_q; c_d = c_q; idx_d = idx_q;
    dr_d = dr_q; dc_d = dc_q; pend_d = 1'b0; pzero_d = pzero_q;
    pdr_d = pdr_q; pdc_d = pdc_q; inner_d = inner_q; outer_d = outer_q;
    p1_d = p1_q; p2_d = p2_q; v_d = v_q; res_d = res_q; roff_d = roff_q;
    lfsr_d = lfsr_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_bank = bank_q;
    wr_addr = idx_q; wr_data = '0; in_ready_o = 1'b0; res_o = '0;
    ln = gca_pkg::lfsr_next(lfsr_q);

    on_grid = (32'(in_item_i.cell_row) < 32'(GRID_ROWS)) &&
              (32'(in_item_i.cell_col) < 32'(GRID_COLS));

    // neighbour coordinate of the current offset
    nr = int'(r_q) + int'(dr_q);
    nc = int'(c_q) + int'(dc_q);
    in_grid = 1'b1;
    if (cfg_i.wrap) begin
      if (nr < 0) nr = nr + GRID_ROWS;
      else if (nr >= GRID_ROWS) nr = nr - GRID_ROWS;
      if (nc < 0) nc = nc + GRID_COLS;
      else if (nc >= GRID_COLS) nc = nc - GRID_COLS;
    end else if (nr < 0 || nr >= GRID_ROWS || nc < 0 || nc >= GRID_COLS) begin
      in_grid = 1'b0;
      nr = 0;
      nc = 0;
    end

    // accumulate the gray that came back from the read issued last cycle
    ar = pdr_q[2] ? 3'(-pdr_q) : 3'(pdr_q);
    ac = pdc_q[2] ? 3'(-pdc_q) : 3'(pdc_q);
    g  = pzero_q ? 8'd0 : rdata;
    if (pend_q) begin
      if (ar == 3'd0 && ac == 3'd0) begin
        v_d = g;
      end else begin
        if (ar <= 3'd1 && ac <= 3'd1) inner_d = inner_q + 11'(g);
        else outer_d = outer_q + 12'(g);
        if (ar + ac == 3'd1) p1_d = p1_q + 10'(g);
        if (ar + ac <= 3'd2) p2_d = p2_q + 12'(g);
      end
    end

    // neighbour sum for the selected mode
    unique case (cfg_i.mode)
      gca_pkg::MODE_MOORE1: sum = 13'(inner_q);
      gca_pkg::MODE_MOORE2: sum = 13'(inner_q) + 13'(outer_q);
      gca_pkg::MODE_VN1:    sum = 13'(p1_q);
      gca_pkg::MODE_VN2:    sum = 13'(p2_q);
      gca_pkg::MODE_WEIGHT: sum = 13'(inner_q) + 13'(outer_q[11:1]);
      default:              sum = 13'd0;
    endcase
    live_ok  = (sum >= cfg_i.survive_low) && (sum <= cfg_i.survive_high);
    birth_ok = (sum >= cfg_i.birth_low) && (sum <= cfg_i.birth_high);
    newv = v_q;

    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_bank = 1'b0;
        idx_d = idx_q + 1'b1;
        if (idx_q == AW'(CELLS - 1)) begin
          idx_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          unique case (in_item_i.cmd)
            gca_pkg::CMD_WRITE: begin
              wr_en = on_grid;
              wr_addr = AW'(32'(in_item_i.cell_row) * GRID_COLS +
                            32'(in_item_i.cell_col));
              wr_data = in_item_i.cell_value;
              state_d = S_PUSH;
            end
            gca_pkg::CMD_READ: begin
              rd_en = on_grid;
              rd_addr = AW'(32'(in_item_i.cell_row) * GRID_COLS +
                            32'(in_item_i.cell_col));
              roff_d = !on_grid;
              state_d = S_RDWAIT;
            end
            gca_pkg::CMD_GEN: begin
              r_d = '0; c_d = '0; idx_d = '0;
              dr_d = -3'sd2; dc_d = -3'sd2;
              inner_d = '0; outer_d = '0; p1_d = '0; p2_d = '0;
              state_d = S_GRD;
            end
            default: begin
              idx_d = '0;
              state_d = S_RAND;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_d = roff_q ? 8'd0 : rdata;
        state_d = S_PUSH;
      end
      S_GRD: begin
        rd_en = in_grid;
        rd_addr = AW'(nr * GRID_COLS + nc);
        pend_d = 1'b1;
        pzero_d = !in_grid;
        pdr_d = dr_q;
        pdc_d = dc_q;
        if (dc_q == 3'sd2) begin
          dc_d = -3'sd2;
          if (dr_q == 3'sd2) begin
            dr_d = -3'sd2;
            state_d = S_GACC;
          end else begin
            dr_d = dr_q + 3'sd1;
          end
        end else begin
          dc_d = dc_q + 3'sd1;
        end
      end
      S_GACC: begin
        state_d = S_GWR;
      end
      S_GWR: begin
        // survive, die or give birth
        if (v_q != 8'd0) begin
          if (!live_ok) newv = 8'd0;
        end else if (birth_ok) begin
          lfsr_d = ln;
          newv = gca_pkg::gray_of(ln);
        end
        wr_en = 1'b1;
        wr_bank = !bank_q;
        wr_data = newv;
        inner_d = '0; outer_d = '0; p1_d = '0; p2_d = '0;
        idx_d = idx_q + 1'b1;
        state_d = S_GRD;
        if (c_q == CW'(GRID_COLS - 1)) begin
          c_d = '0;
          if (r_q == RW'(GRID_ROWS - 1)) begin
            r_d = '0;
            idx_d = '0;
            bank_d = !bank_q;
            state_d = S_PUSH;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      S_RAND: begin
        lfsr_d = ln;
        wr_en = 1'b1;
        wr_data = gca_pkg::gray_of(ln);
        idx_d = idx_q + 1'b1;
        if (idx_q == AW'(CELLS - 1)) begin
          idx_d = '0;
          state_d = S_PUSH;
        end
      end
      default: begin
        // hand the result to the output register
        if (out_free_i) begin
          res_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
    res_o.value = res_q;

    // seed load, zero maps to one
    if (cfg_i.seed_wr) begin
      lfsr_d = (cfg_i.seed == 16'd0) ? 16'd1 : cfg_i.seed;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      bank_q  <= 1'b0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      lfsr_q  <= 16'd1;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      lfsr_q  <= lfsr_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    r_q <= r_d; c_q <= c_d; dr_q <= dr_d; dc_q <= dc_d;
    pzero_q <= pzero_d; pdr_q <= pdr_d; pdc_q <= pdc_d;
    inner_q <= inner_d; outer_q <= outer_d; p1_q <= p1_d; p2_q <= p2_d;
    v_q <= v_d; res_q <= res_d; roff_q <= roff_d;
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_graded_cell_automaton.sv
// testbench for the graded cell grid: command stimulus with a cycle-free predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_graded_cell_automaton;

  localparam int ROWS = gca_pkg::GRID_ROWS_DEF;
  localparam int COLS = gca_pkg::GRID_COLS_DEF;
  localparam int CELLS = ROWS * COLS;

  // grid model and result checker
  class grid_scoreboard;
    logic [7:0]  grid [CELLS];
    logic [7:0]  scratch [CELLS];
    logic [15:0] lfsr;
    logic [2:0]  mode;
    logic        wrap;
    logic [12:0] birth_lo, birth_hi, surv_lo, surv_hi;
    gca_pkg::out_item_t expected_q [$];
    int          errors;

    function new();
      foreach (grid[i]) grid[i] = '0;
      lfsr = 16'd1;
      mode = gca_pkg::MODE_MOORE1;
      wrap = 1'b1;
      birth_lo = 13'd510;
      birth_hi = 13'd765;
      surv_lo = 13'd255;
      surv_hi = 13'd765;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        gca_pkg::REG_MODE:  mode = data[2:0];
        gca_pkg::REG_WRAP:  wrap = data[0];
        gca_pkg::REG_BLOW:  birth_lo = data[12:0];
        gca_pkg::REG_BHIGH: birth_hi = data[12:0];
        gca_pkg::REG_SLOW:  surv_lo = data[12:0];
        gca_pkg::REG_SHIGH: surv_hi = data[12:0];
        gca_pkg::REG_SEED:  lfsr = (data == 16'd0) ? 16'd1 : data;
        default: ;
      endcase
    endfunction

    // advance the galois register and fold to a gray
    function logic [7:0] next_gray();
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ gca_pkg::LFSR_MASK) : (lfsr >> 1);
      return 8'(lfsr % 255);
    endfunction

    function int cell_at(int r, int c);
      if (wrap) begin
        r = (r + 2 * ROWS) % ROWS;
        c = (c + 2 * COLS) % COLS;
      end else if (r < 0 || r >= ROWS || c < 0 || c >= COLS) begin
        return 0;
      end
      return grid[r * COLS + c];
    endfunction

    function int area_sum(int r, int c);
      int inner, outer, ring1, ring2, g, ar, ac;
      inner = 0; outer = 0; ring1 = 0; ring2 = 0;
      for (int dr = -2; dr <= 2; dr++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          ar = dr < 0 ? -dr : dr;
          ac = dc < 0 ? -dc : dc;
          if (ar != 0 || ac != 0) begin
            g = cell_at(r + dr, c + dc);
            if (ar <= 1 && ac <= 1) inner += g;
            else outer += g;
            if (ar + ac == 1) ring1 += g;
            if (ar + ac <= 2) ring2 += g;
          end
        end
      end
      case (mode)
        gca_pkg::MODE_MOORE1: return inner;
        gca_pkg::MODE_MOORE2: return inner + outer;
        gca_pkg::MODE_VN1:    return ring1;
        gca_pkg::MODE_VN2:    return ring2;
        gca_pkg::MODE_WEIGHT: return (2 * inner + outer) / 2;
        default:              return 0;
      endcase
    endfunction

    function void step_generation();
      int s;
      logic [7:0] v;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          s = area_sum(r, c);
          v = grid[r * COLS + c];
          if (v != 0) begin
            if (!(s >= surv_lo && s <= surv_hi)) v = 8'd0;
          end else if (s >= birth_lo && s <= birth_hi) begin
            v = next_gray();
          end
          scratch[r * COLS + c] = v;
        end
      end
      grid = scratch;
    endfunction

    // note an accepted command and queue its result
    function void note_item(gca_pkg::in_item_t it);
      gca_pkg::out_item_t res;
      res.read_value = 8'd0;
      res.op_done = 1'b1;
      case (it.cmd)
        gca_pkg::CMD_WRITE: grid[it.cell_row * COLS + it.cell_col] = it.cell_value;
        gca_pkg::CMD_READ:  res.read_value = grid[it.cell_row * COLS + it.cell_col];
        gca_pkg::CMD_GEN:   step_generation();
        default:            foreach (grid[i]) grid[i] = next_gray();
      endcase
      expected_q.push_back(res);
    endfunction

    task check_result(gca_pkg::out_item_t got);
      gca_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (got.read_value !== want.read_value)
          report($sformatf("read_value %0d, expected %0d", got.read_value, want.read_value));
        if (got.op_done !== want.op_done)
          report($sformatf("op_done %0b, expected %0b", got.op_done, want.op_done));
      end
    endtask
  endclass

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic       in_valid_i, in_ready_o;
  gca_pkg::in_item_t  in_item_i;
  logic       out_valid_o, out_ready_i;
  gca_pkg::out_item_t out_item_o;

  grid_scoreboard sb;
  int hold_off_cycles;
  int last_row, last_col;

  graded_cell_automaton DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #(64'd20 * 64'd4_000_000);
    $display("tb: failure");
    $finish;
  end

  function int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result sink with random back-pressure and a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_off_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready_i <= (pick_gap() == 0);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // called at a falling edge; returns at a falling edge
  task send_item(gca_pkg::in_item_t it);
    int gap;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    if (it.cmd == gca_pkg::CMD_WRITE) begin
      last_row = it.cell_row;
      last_col = it.cell_col;
    end
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task send_cmd(logic [1:0] cmd, int row, int col, int value);
    gca_pkg::in_item_t it;
    it.cmd = cmd;
    it.cell_row = 6'(row);
    it.cell_col = 6'(col);
    it.cell_value = 8'(value);
    send_item(it);
  endtask

  // wait until every queued result has come back
  task drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(data);
    sb.set_reg(idx, 16'(data));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task load_setting(int m, int w, int blo, int bhi, int slo, int shi, int seed);
    write_reg(gca_pkg::REG_MODE, m);
    write_reg(gca_pkg::REG_WRAP, w);
    write_reg(gca_pkg::REG_BLOW, blo);
    write_reg(gca_pkg::REG_BHIGH, bhi);
    write_reg(gca_pkg::REG_SLOW, slo);
    write_reg(gca_pkg::REG_SHIGH, shi);
    write_reg(gca_pkg::REG_SEED, seed);
  endtask

  // random commands with one generation, reads often aimed at written cells
  task random_phase(int count, bit scramble);
    int gen_at;
    gen_at = $urandom_range(count / 2, count - 1);
    if (scramble) send_cmd(gca_pkg::CMD_RAND, $urandom, $urandom, $urandom);
    for (int n = 0; n < count; n++) begin
      if (n == gen_at) begin
        send_cmd(gca_pkg::CMD_GEN, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 1)) begin
        send_cmd(gca_pkg::CMD_WRITE, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 1)) begin
        send_cmd(gca_pkg::CMD_READ, last_row, last_col, $urandom);
      end else begin
        send_cmd(gca_pkg::CMD_READ, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = gca_pkg::REG_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    last_row = 0;
    last_col = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, extremes, every command under reset settings
    send_cmd(gca_pkg::CMD_READ, 0, 0, 0);
    send_cmd(gca_pkg::CMD_WRITE, 0, 0, 255);
    send_cmd(gca_pkg::CMD_WRITE, 63, 63, 255);
    send_cmd(gca_pkg::CMD_WRITE, 0, 63, 170);
    send_cmd(gca_pkg::CMD_WRITE, 63, 0, 85);
    send_cmd(gca_pkg::CMD_WRITE, 1, 1, 1);
    send_cmd(gca_pkg::CMD_READ, 0, 0, 255);
    send_cmd(gca_pkg::CMD_READ, 63, 63, 0);
    send_cmd(gca_pkg::CMD_READ, 0, 63, 0);
    send_cmd(gca_pkg::CMD_READ, 63, 0, 0);
    send_cmd(gca_pkg::CMD_WRITE, 1, 1, 0);
    send_cmd(gca_pkg::CMD_READ, 1, 1, 0);
    send_cmd(gca_pkg::CMD_RAND, 42, 21, 7);
    send_cmd(gca_pkg::CMD_READ, 0, 0, 0);
    send_cmd(gca_pkg::CMD_READ, 63, 63, 0);
    send_cmd(gca_pkg::CMD_WRITE, 32, 32, 0);
    send_cmd(gca_pkg::CMD_GEN, 0, 0, 0);
    send_cmd(gca_pkg::CMD_READ, 32, 32, 0);
    send_cmd(gca_pkg::CMD_READ, 0, 0, 0);
    send_cmd(gca_pkg::CMD_READ, 63, 63, 0);

    // long receiver hold-off while reads keep coming, so the input stalls
    hold_off_cycles = 60;
    for (int n = 0; n < 8; n++) send_cmd(gca_pkg::CMD_READ, $urandom, $urandom, 0);
    drain();

    // wide open intervals, no wrap, seed of zero
    load_setting(gca_pkg::MODE_MOORE2, 0, 0, 6120, 0, 6120, 0);
    random_phase(24, 1'b1);
    drain();

    // empty survive interval, top seed
    load_setting(gca_pkg::MODE_VN1, 1, 300, 600, 8191, 0, 65535);
    random_phase(24, 1'b1);
    drain();

    // extreme single-point intervals
    load_setting(gca_pkg::MODE_VN2, 0, 6120, 6120, 0, 0, $urandom_range(1, 65535));
    random_phase(22, 1'b0);
    drain();

    // weighted sum with random bounds
    load_setting(gca_pkg::MODE_WEIGHT, 1, $urandom_range(0, 3000),
                 $urandom_range(2000, 6120),
                 $urandom_range(0, 3000), $urandom_range(2000, 8191),
                 $urandom_range(1, 65535));
    random_phase(24, 1'b1);
    drain();

    // unknown mode: every sum is zero
    load_setting($urandom_range(5, 7), 0, 0, 0, 0, 8191, $urandom_range(1, 65535));
    random_phase(22, 1'b1);
    drain();

    repeat (50) @(posedge clk_i);
    if (sb.expected_q.size() > 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: graded_cell_automaton.f
rtl/gca_pkg.sv
rtl/gca_ram.sv
rtl/gca_engine.sv
rtl/graded_cell_automaton.sv
tb/sv/tb_graded_cell_automaton.sv
